// ----- sv/ssm_pkg.sv -----
// Shared types, codes and constants of the sparse set membership block.
package ssm_pkg;

    localparam int KEY_W       = 10;
    localparam int POS_W       = 10;
    localparam int SIZE_W      = 11;
    localparam int STATUS_W    = 2;
    localparam int MAX_KEYS_DEF = 1024;

    localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 11'd1024;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    localparam logic [STATUS_W-1:0] ST_APPLIED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_EFFECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd2;

    typedef struct packed {
        cmd_t              command;
        logic [KEY_W-1:0]  key;
        logic [POS_W-1:0]  position;
    } in_item_t;

    typedef struct packed {
        logic                is_member;
        logic [SIZE_W-1:0]   set_size;
        logic [KEY_W-1:0]    read_key;
        logic [STATUS_W-1:0] status;
    } out_item_t;

endpackage

// ----- sv/ssm_index_ram.sv -----
// Sparse index table: one write port, one registered read port.
module ssm_index_ram #(
    parameter int DEPTH  = ssm_pkg::MAX_KEYS_DEF,
    parameter int ADDR_W = $clog2(ssm_pkg::MAX_KEYS_DEF)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ADDR_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ADDR_W-1:0] rdata
);

    logic [ADDR_W-1:0] mem_reg [DEPTH];
    logic [ADDR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ssm_key_ram.sv -----
// Packed key list: one write port, two registered read ports.
module ssm_key_ram #(
    parameter int DEPTH  = ssm_pkg::MAX_KEYS_DEF,
    parameter int ADDR_W = $clog2(ssm_pkg::MAX_KEYS_DEF)
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [ssm_pkg::KEY_W-1:0]  wdata,
    input  logic                       re_a,
    input  logic [ADDR_W-1:0]          raddr_a,
    output logic [ssm_pkg::KEY_W-1:0]  rdata_a,
    input  logic                       re_b,
    input  logic [ADDR_W-1:0]          raddr_b,
    output logic [ssm_pkg::KEY_W-1:0]  rdata_b
);

    logic [ssm_pkg::KEY_W-1:0] mem_reg [DEPTH];
    logic [ssm_pkg::KEY_W-1:0] rdata_a_reg;
    logic [ssm_pkg::KEY_W-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a_reg <= mem_reg[raddr_a];
        end
        if (re_b) begin
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- sv/sparse_set_membership.sv -----
// Sparse set of small keys with swap-remove: control, count and result register.
// An accepted input beat passes S_LOOK, then S_DECIDE registers its result once the result
// register is free; no new beat is taken meanwhile. Steps: index read, packed key read at that index,
// then decide and write back; the dependent pair of synchronous memory reads sets this order.
// Reset clears the count and sets the active size to 1024; the index table is then swept
// to zero across all MAX_KEYS entries (1024 by default), during which no input beat is taken.
module sparse_set_membership #(
    parameter int MAX_KEYS = ssm_pkg::MAX_KEYS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ssm_pkg::SIZE_W-1:0]        cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ssm_pkg::in_item_t                 s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ssm_pkg::out_item_t                m_item
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DECIDE
    } state_t;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              clr_reg, clr_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [ssm_pkg::SIZE_W-1:0] active_size_reg, active_size_next;
    ssm_pkg::in_item_t          item_reg, item_next;
    ssm_pkg::out_item_t         m_item_reg, m_item_next;
    logic                       m_valid_reg, m_valid_next;

    logic                       accept;
    logic                       out_free;
    logic                       go;
    logic                       in_range;
    logic                       present;
    logic                       add_ok;
    logic                       rem_ok;
    logic                       rd_ok;

    logic                       idx_we;
    logic [AW-1:0]              idx_waddr;
    logic [AW-1:0]              idx_wdata;
    logic [AW-1:0]              idx_q;

    logic                       key_we;
    logic [AW-1:0]              key_waddr;
    logic [ssm_pkg::KEY_W-1:0]  key_wdata;
    logic [AW-1:0]              key_raddr_b;
    logic [ssm_pkg::KEY_W-1:0]  hole_key_q;
    logic [ssm_pkg::KEY_W-1:0]  tail_q;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign go       = (state_reg == S_DECIDE) && out_free;

    // Port B fetches the read position or the tail of the packed list
    assign key_raddr_b = (s_item.command == ssm_pkg::CMD_READ) ?
                         AW'(s_item.position) : AW'(count_reg - CW'(1));

    assign in_range = ({1'b0, item_reg.key} < active_size_reg)
                   && (32'(item_reg.key) < MAX_KEYS);

    // A key is a member when its index points below the count at a slot holding it
    assign present = in_range && (CW'(idx_q) < count_reg) && (hole_key_q == item_reg.key);

    assign add_ok = (item_reg.command == ssm_pkg::CMD_ADD) && in_range && !present
                 && (count_reg < CW'(MAX_KEYS));
    assign rem_ok = (item_reg.command == ssm_pkg::CMD_REMOVE) && present;
    assign rd_ok  = (item_reg.command == ssm_pkg::CMD_READ)
                 && (32'(item_reg.position) < 32'(count_reg));

    always_comb begin
        idx_we    = 1'b0;
        idx_waddr = clr_reg;
        idx_wdata = '0;
        key_we    = go && (add_ok || rem_ok);
        key_waddr = add_ok ? AW'(count_reg) : idx_q;
        key_wdata = add_ok ? item_reg.key : tail_q;
        if (state_reg == S_CLEAR) begin
            idx_we = 1'b1;
        end else if (go && (add_ok || rem_ok)) begin
            idx_we    = 1'b1;
            // Remove repoints the tail key at the hole; add points the key at the end
            idx_waddr = add_ok ? AW'(item_reg.key) : AW'(tail_q);
            idx_wdata = add_ok ? AW'(count_reg) : idx_q;
        end
    end

    always_comb begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        count_next       = count_reg;
        active_size_next = cfg_wr_en ? cfg_wr_data : active_size_reg;
        item_next        = accept ? s_item : item_reg;
        m_item_next      = m_item_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_KEYS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                // Hold until the result register is free
                if (go) begin
                    if (add_ok) begin
                        count_next = count_reg + CW'(1);
                    end else if (rem_ok) begin
                        count_next = count_reg - CW'(1);
                    end
                    m_item_next.is_member = add_ok ? 1'b1 : (rem_ok ? 1'b0 : present);
                    m_item_next.set_size  = ssm_pkg::SIZE_W'(count_next);
                    m_item_next.read_key  = rd_ok ? tail_q : '0;
                    if (item_reg.command == ssm_pkg::CMD_READ) begin
                        m_item_next.status = rd_ok ? ssm_pkg::ST_APPLIED : ssm_pkg::ST_BAD_POS;
                    end else if (item_reg.command == ssm_pkg::CMD_TEST) begin
                        m_item_next.status = ssm_pkg::ST_APPLIED;
                    end else begin
                        m_item_next.status = (add_ok || rem_ok) ?
                                             ssm_pkg::ST_APPLIED : ssm_pkg::ST_NO_EFFECT;
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            count_reg       <= '0;
            active_size_reg <= ssm_pkg::ACTIVE_SIZE_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            count_reg       <= count_next;
            active_size_reg <= active_size_next;
            m_valid_reg     <= m_valid_next;
        end
        item_reg   <= item_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    ssm_index_ram #(
        .DEPTH  (MAX_KEYS),
        .ADDR_W (AW)
    ) u_index_ram (
        .aclk  (aclk),
        .we    (idx_we),
        .waddr (idx_waddr),
        .wdata (idx_wdata),
        .re    (accept),
        .raddr (AW'(s_item.key)),
        .rdata (idx_q)
    );

    ssm_key_ram #(
        .DEPTH  (MAX_KEYS),
        .ADDR_W (AW)
    ) u_key_ram (
        .aclk    (aclk),
        .we      (key_we),
        .waddr   (key_waddr),
        .wdata   (key_wdata),
        .re_a    (state_reg == S_LOOK),
        .raddr_a (idx_q),
        .rdata_a (hole_key_q),
        .re_b    (accept),
        .raddr_b (key_raddr_b),
        .rdata_b (tail_q)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_KEYS))
        else $error("member count beyond capacity");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && add_ok) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("add did not grow the set");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && rem_ok) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("remove did not shrink the set");

    a_result_size: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> (m_valid && (m_item.set_size == ssm_pkg::SIZE_W'(count_reg))))
        else $error("result size does not match count");

endmodule
